>>> rtl/joint_setpoint_rate_accel_limiter_defines.svh
// Assertion macros for the joint setpoint rate and acceleration limiter.
// Included by the RTL files that carry assertions; depends on nothing.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef JOINT_SETPOINT_RATE_ACCEL_LIMITER_DEFINES_SVH
`define JOINT_SETPOINT_RATE_ACCEL_LIMITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define JSRAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define JSRAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JSRAL_ASSERT(label, clk, rst, prop, msg)
`define JSRAL_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/jsral_pkg.sv
// Shared types, constants and clamp functions of the setpoint limiter.
// Used by jsral_csr, jsral_datapath and the top level; depends on nothing.
package jsral_pkg;

   localparam int POS_W      = 27;
   localparam int STEP_W     = 21;
   localparam int GAIN_W     = 16;
   localparam int SLIM_W     = 20;
   localparam int ALIM_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;
   localparam int WIDE_W     = POS_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOLLOW_GAIN   = 3'd0,
      CSR_POSITION_LOW  = 3'd1,
      CSR_POSITION_HIGH = 3'd2,
      CSR_STEP_LIMIT    = 3'd3,
      CSR_ACCEL_LIMIT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        [GAIN_W-1:0] follow_gain;
      logic signed [POS_W-1:0]  position_low;
      logic signed [POS_W-1:0]  position_high;
      logic        [SLIM_W-1:0] step_limit;
      logic        [ALIM_W-1:0] accel_limit;
   } cfg_type;

   localparam logic        [GAIN_W-1:0] FOLLOW_GAIN_RST   = 16'd328;
   localparam logic signed [POS_W-1:0]  POSITION_LOW_RST  = -27'sd48234496;
   localparam logic signed [POS_W-1:0]  POSITION_HIGH_RST = 27'sd48234496;
   localparam logic        [SLIM_W-1:0] STEP_LIMIT_RST    = 20'd36490;
   localparam logic        [ALIM_W-1:0] ACCEL_LIMIT_RST   = 16'd252;

   // On a reversed window, values below the low edge give the low edge and all others the high edge.
   function automatic logic signed [POS_W-1:0] window_clamp(
      input logic signed [WIDE_W-1:0] q,
      input logic signed [POS_W-1:0]  lo,
      input logic signed [POS_W-1:0]  hi);
      logic signed [WIDE_W-1:0] lo_x;
      logic signed [WIDE_W-1:0] hi_x;
      logic signed [POS_W-1:0]  r;
      lo_x = $signed({lo[POS_W-1], lo});
      hi_x = $signed({hi[POS_W-1], hi});
      if (q < lo_x) begin
         r = lo;
      end else if (q > hi_x) begin
         r = hi;
      end else begin
         r = q[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sym_clamp(
      input logic signed [WIDE_W-1:0] v,
      input logic        [POS_W-1:0]  lim);
      logic signed [WIDE_W-1:0] lim_s;
      logic signed [WIDE_W-1:0] r;
      lim_s = $signed({1'b0, lim});
      if (v > lim_s) begin
         r = lim_s;
      end else if (v < -lim_s) begin
         r = -lim_s;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> rtl/jsral_csr.sv
// Configuration register file of the setpoint limiter.
// Depends on jsral_pkg for the index codes, reset values and cfg_type.
module jsral_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jsral_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jsral_pkg::CSR_DATA_W-1:0]     csr_data,
   output jsral_pkg::cfg_type                   cfg
);

   jsral_pkg::cfg_type cfg_ff;
   jsral_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (jsral_pkg::csr_index_type'(csr_index))
            jsral_pkg::CSR_FOLLOW_GAIN: begin
               cfg_in.follow_gain = csr_data[jsral_pkg::GAIN_W-1:0];
            end
            jsral_pkg::CSR_POSITION_LOW: begin
               cfg_in.position_low = $signed(csr_data[jsral_pkg::POS_W-1:0]);
            end
            jsral_pkg::CSR_POSITION_HIGH: begin
               cfg_in.position_high = $signed(csr_data[jsral_pkg::POS_W-1:0]);
            end
            jsral_pkg::CSR_STEP_LIMIT: begin
               cfg_in.step_limit = csr_data[jsral_pkg::SLIM_W-1:0];
            end
            jsral_pkg::CSR_ACCEL_LIMIT: begin
               cfg_in.accel_limit = csr_data[jsral_pkg::ALIM_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.follow_gain   <= jsral_pkg::FOLLOW_GAIN_RST;
         cfg_ff.position_low  <= jsral_pkg::POSITION_LOW_RST;
         cfg_ff.position_high <= jsral_pkg::POSITION_HIGH_RST;
         cfg_ff.step_limit    <= jsral_pkg::STEP_LIMIT_RST;
         cfg_ff.accel_limit   <= jsral_pkg::ACCEL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/jsral_datapath.sv
// One-tick shaping datapath: window, gain, step clamp, accel clamp, window; a first
// tick loads present_command, zero step. Combinational; jsral_pkg gives widths, clamps.
module jsral_datapath (
   input  jsral_pkg::cfg_type                      cfg,
   input  logic                                    started,
   input  logic signed [jsral_pkg::POS_W-1:0]      held_command,
   input  logic signed [jsral_pkg::STEP_W-1:0]     last_step,
   input  logic signed [jsral_pkg::POS_W-1:0]      target_position,
   input  logic signed [jsral_pkg::POS_W-1:0]      present_command,
   output logic signed [jsral_pkg::POS_W-1:0]      next_command,
   output logic signed [jsral_pkg::STEP_W-1:0]     next_step
);

   localparam int WW    = jsral_pkg::WIDE_W;
   localparam int PW    = jsral_pkg::POS_W;
   localparam int SW    = jsral_pkg::STEP_W;
   localparam int PROD_W = WW + jsral_pkg::GAIN_W + 1;
   localparam int FRAC_W = jsral_pkg::GAIN_W;

   logic signed [PW-1:0]     tgt;
   logic signed [WW-1:0]     err;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [WW-1:0]     raw_step;
   logic signed [WW-1:0]     rate_step;
   logic signed [WW-1:0]     last_x;
   logic signed [WW-1:0]     dstep;
   logic signed [WW-1:0]     step_w;
   logic signed [SW-1:0]     step;
   logic signed [WW-1:0]     sum;

   assign tgt = jsral_pkg::window_clamp($signed({target_position[PW-1], target_position}),
                                        cfg.position_low, cfg.position_high);
   assign err = $signed({tgt[PW-1], tgt}) - $signed({held_command[PW-1], held_command});

   assign prod = $signed({{(PROD_W-jsral_pkg::GAIN_W){1'b0}}, cfg.follow_gain})
               * $signed({{(PROD_W-WW){err[WW-1]}}, err});
   assign prod_rnd = prod + $signed(PROD_W'(1) <<< (FRAC_W - 1));
   assign raw_step = prod_rnd[FRAC_W+WW-1:FRAC_W];

   assign rate_step = jsral_pkg::sym_clamp(raw_step,
                         {{(PW-jsral_pkg::SLIM_W){1'b0}}, cfg.step_limit});
   assign last_x    = $signed({{(WW-SW){last_step[SW-1]}}, last_step});
   assign dstep     = jsral_pkg::sym_clamp(rate_step - last_x,
                         {{(PW-jsral_pkg::ALIM_W){1'b0}}, cfg.accel_limit});
   assign step_w    = last_x + dstep;
   assign step      = step_w[SW-1:0];
   assign sum       = $signed({held_command[PW-1], held_command})
                    + $signed({{(WW-SW){step[SW-1]}}, step});

   always_comb begin
      if (!started) begin
         next_command = present_command;
         next_step    = '0;
      end else begin
         next_command = jsral_pkg::window_clamp(sum, cfg.position_low, cfg.position_high);
         next_step    = step;
      end
   end

endmodule

>>> rtl/joint_setpoint_rate_accel_limiter.sv
// Single-joint setpoint shaper with position window, rate and acceleration limits.
// Request channel (req_): one control tick per transfer, target_position and
// present_command in Q24 radians. Response channel (rsp_): one transfer per
// request, the shaped commanded_position and the applied_step of that tick.
// Configuration channel (csr_): register writes by index, always ready; write
// only while no tick is in flight.
// Path: a taken request is registered in the request register, shaped by
// jsral_datapath, and registered in the response register when that is free.
// Throughput: one tick per cycle unless rsp_stall holds the response; the loop
// through held state closes in the combinational shaping, which sets the rate.
// Reset: limits return to their defaults, held command and last step clear,
// and the first tick after reset loads present_command with a zero step.
// Stall: rsp_stall holds the response register; the request register still
// fills behind it, and req_stall rises only when both are occupied.
// Depends on jsral_pkg, jsral_csr, jsral_datapath and the assertion macros.
`include "joint_setpoint_rate_accel_limiter_defines.svh"

module joint_setpoint_rate_accel_limiter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [jsral_pkg::POS_W-1:0]      req_target_position,
   input  logic signed [jsral_pkg::POS_W-1:0]      req_present_command,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [jsral_pkg::POS_W-1:0]      rsp_commanded_position,
   output logic signed [jsral_pkg::STEP_W-1:0]     rsp_applied_step,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [jsral_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jsral_pkg::CSR_DATA_W-1:0]        csr_data
);

   jsral_pkg::cfg_type cfg;

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic signed [jsral_pkg::POS_W-1:0]     in_target_ff;
   logic signed [jsral_pkg::POS_W-1:0]     in_present_ff;

   logic                                   started_ff;
   logic signed [jsral_pkg::POS_W-1:0]     held_command_ff;
   logic signed [jsral_pkg::STEP_W-1:0]    last_step_ff;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic signed [jsral_pkg::POS_W-1:0]     rsp_command_ff;
   logic signed [jsral_pkg::STEP_W-1:0]    rsp_step_ff;

   logic signed [jsral_pkg::POS_W-1:0]     next_command;
   logic signed [jsral_pkg::STEP_W-1:0]    next_step;
   logic                                   out_free;
   logic                                   advance;
   logic                                   req_take;

   jsral_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jsral_datapath u_datapath (
      .cfg             (cfg),
      .started         (started_ff),
      .held_command    (held_command_ff),
      .last_step       (last_step_ff),
      .target_position (in_target_ff),
      .present_command (in_present_ff),
      .next_command    (next_command),
      .next_step       (next_step)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? advance : rsp_valid_ff;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_commanded_position = rsp_command_ff;
   assign rsp_applied_step       = rsp_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         started_ff      <= 1'b0;
         held_command_ff <= '0;
         last_step_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            started_ff      <= 1'b1;
            held_command_ff <= next_command;
            last_step_ff    <= next_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_target_ff  <= req_target_position;
         in_present_ff <= req_present_command;
      end
      if (advance) begin
         rsp_command_ff <= next_command;
         rsp_step_ff    <= next_step;
      end
   end

   `JSRAL_ASSERT(a_first_tick_loads, clock, reset, (advance && !started_ff) |=> (rsp_applied_step == '0 && rsp_commanded_position == $past(in_present_ff)), "first tick must load present command with zero step")
   `JSRAL_ASSERT(a_state_matches_rsp, clock, reset, advance |=> (held_command_ff == rsp_commanded_position && last_step_ff == rsp_applied_step), "state and response disagree after a transfer")
   `JSRAL_ASSERT(a_in_not_lost, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_target_ff) && $stable(in_present_ff)), "held request lost or changed")
   `JSRAL_ASSERT(a_cmd_in_window, clock, reset, (advance && started_ff && cfg.position_low <= cfg.position_high) |=> (rsp_commanded_position >= $past(cfg.position_low) && rsp_commanded_position <= $past(cfg.position_high)), "command left the position window")
   `JSRAL_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> (!rsp_valid_ff && !in_valid_ff && !started_ff), "reset did not clear control state")

endmodule
